[hw/rtl/fixed_block_pool_allocator_macros.svh]
// Assertion macros shared by the pool allocator RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define FBPA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define FBPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/fbpa_pkg.sv]
// Shared types and constants of the fixed block pool allocator.
// No dependencies; imported by every module of the block.
package fbpa_pkg;

    localparam int FIELD_AW = 48;   // address field width on the ports
    localparam int SIZE_W   = 13;   // block_size register width
    localparam int COUNT_W  = 11;   // block_count register width
    localparam int CFG_IDX_W = 2;

    localparam logic [SIZE_W-1:0]   MIN_BLOCK_BYTES  = 13'd5;
    localparam logic [SIZE_W-1:0]   RST_BLOCK_SIZE   = 13'd64;
    localparam logic [COUNT_W-1:0]  RST_BLOCK_COUNT  = 11'd1024;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd2;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_RANGE     = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_ALLOC_END,
        S_FREE_CHK,
        S_FREE_TST,
        S_FREE_DIV,
        S_REPLY
    } t_state;

endpackage

[hw/rtl/fbpa_div.sv]
// Radix-2 restoring divider: one quotient bit per cycle.
// Depends on fbpa_pkg for the divisor width.
module fbpa_div
    import fbpa_pkg::*;
#(
    parameter int DW = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DW-1:0]     i_dividend,
    input  logic [SIZE_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DW-1:0]     o_quotient
);

    localparam int CNT_W = $clog2(DW + 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [DW-1:0]     r_quo, n_quo;
    logic [SIZE_W-1:0] r_rem, n_rem;
    logic [SIZE_W-1:0] r_dvs, n_dvs;
    logic [SIZE_W:0]   w_trial;
    logic              w_fits;

    // Shift the next dividend bit into the partial remainder
    assign w_trial = {r_rem, r_quo[DW-1]};
    assign w_fits  = (w_trial >= {1'b0, r_dvs});

    // Load on start, then one restoring step per cycle
    always_comb begin
        n_busy = r_busy;
        n_done = r_done;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_done = 1'b0;
            n_cnt  = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[DW-2:0], w_fits};
            n_rem = w_fits ? SIZE_W'(w_trial - {1'b0, r_dvs}) : w_trial[SIZE_W-1:0];
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(DW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // Datapath registers need no reset
    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[hw/rtl/fbpa_link_mem.sv]
// Free-list link store: one write port, one read port, registered read data.
// Depends on fbpa_pkg only by convention; contents are undefined until written.
module fbpa_link_mem
    import fbpa_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int DW    = 11
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DW-1:0]            i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DW-1:0]            o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Write link entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read link entry; hold data between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/fixed_block_pool_allocator.sv]
// Top level of the fixed block pool allocator: request sequencer, config registers.
// Depends on fbpa_pkg, fbpa_link_mem, fbpa_div and the assertion macro header.
//
//  channel   | group     | fields (low bit up)
//  request   | s_axis_*  | tuser: op ; tdata: free_addr[47:0]
//  response  | m_axis_*  | tdata: block_addr[47:0], status[49:48], zero pad to 56
//  config    | i_cfg_*   | idx 0 pool_base, 1 block_size, 2 block_count
//
// Allocate passes S_ALLOC and S_ALLOC_END; exhausted and range errors reply from S_REPLY.
// Free passes S_FREE_CHK, S_FREE_TST and S_FREE_DIV, where it waits for the divider, which
// yields one quotient bit per cycle. One request is in flight at a time.
// Synchronous active-low reset returns every block to the pool; link memory is not cleared.
// A stalled response holds; the next request is taken while it waits.
`include "fixed_block_pool_allocator_macros.svh"

module fixed_block_pool_allocator
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS = 1024,
    parameter int ADDR_WIDTH = 48
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // request channel
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [FIELD_AW-1:0]    s_axis_tdata,   // free_addr[47:0]
    input  logic                   s_axis_tuser,   // op
    // response channel
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [55:0]            m_axis_tdata,   // block_addr[47:0], status[49:48]
    // configuration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [FIELD_AW-1:0]    i_cfg_wdata
);

    localparam int CW = $clog2(MAX_BLOCKS + 1);   // count / link value width
    localparam int IW = $clog2(MAX_BLOCKS);       // link memory index width
    localparam int PW = CW + SIZE_W;              // product and offset width
    localparam logic [FIELD_AW-1:0] AMASK = (ADDR_WIDTH >= FIELD_AW) ?
        {FIELD_AW{1'b1}} : FIELD_AW'((64'd1 << ADDR_WIDTH) - 64'd1);

    // Configuration registers
    logic [FIELD_AW-1:0] r_cfg_base;
    logic [SIZE_W-1:0]   r_cfg_size;
    logic [COUNT_W-1:0]  r_cfg_count;

    // Sequencer state
    t_state              r_state, n_state;
    logic [CW-1:0]       r_head, n_head;
    logic [CW-1:0]       r_init, n_init;
    logic [FIELD_AW-1:0] r_addr, n_addr;
    logic [PW-1:0]       r_prod, n_prod;
    logic [FIELD_AW-1:0] r_off, n_off;
    logic                r_lt, n_lt;
    logic                r_fwd, n_fwd;
    t_status             r_status, n_status;

    // Output register
    logic                r_out_valid, n_out_valid;
    logic [FIELD_AW-1:0] r_out_addr, n_out_addr;
    t_status             r_out_status, n_out_status;

    logic [CW-1:0]       w_count;
    logic [SIZE_W-1:0]   w_size;
    logic [FIELD_AW-1:0] w_base;
    logic [CW-1:0]       w_mul_a;
    logic [PW-1:0]       w_mul;
    logic                w_out_free;

    logic                w_mem_we, w_mem_re;
    logic [IW-1:0]       w_mem_waddr, w_mem_raddr;
    logic [CW-1:0]       w_mem_wdata, w_mem_rdata;

    logic                w_div_start, w_div_done;
    logic [PW-1:0]       w_div_quo;

    // Effective configuration
    assign w_count = (32'(r_cfg_count) > 32'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(r_cfg_count);
    assign w_size  = (r_cfg_size < MIN_BLOCK_BYTES) ? MIN_BLOCK_BYTES : r_cfg_size;
    assign w_base  = r_cfg_base & AMASK;

    // Shared multiplier: block offset on allocate, pool span on free
    assign w_mul_a = (r_state == S_ALLOC) ? r_head : w_count;
    assign w_mul   = PW'(w_mul_a) * PW'(w_size);

    assign w_out_free = !r_out_valid || m_axis_tready;

    fbpa_link_mem #(
        .DEPTH (MAX_BLOCKS),
        .DW    (CW)
    ) u_link_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    fbpa_div #(
        .DW (PW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_off[PW-1:0]),
        .i_divisor  (w_size),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    // Next state and datapath control
    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_init       = r_init;
        n_addr       = r_addr;
        n_prod       = r_prod;
        n_off        = r_off;
        n_lt         = r_lt;
        n_fwd        = r_fwd;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_addr   = r_out_addr;
        n_out_status = r_out_status;
        s_axis_tready = 1'b0;
        w_mem_we     = 1'b0;
        w_mem_waddr  = r_init[IW-1:0];
        w_mem_wdata  = r_init + CW'(1);
        w_mem_re     = 1'b0;
        w_mem_raddr  = r_head[IW-1:0];
        w_div_start  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_addr  = s_axis_tdata & AMASK;
                    n_state = (t_op'(s_axis_tuser) == OP_FREE) ? S_FREE_CHK : S_ALLOC;
                end
            end
            S_ALLOC: begin
                if (r_head >= w_count) begin
                    n_status = ST_EXHAUSTED;
                    n_state  = S_REPLY;
                end else begin
                    // link the next never-used block, read the head's successor
                    w_mem_re = 1'b1;
                    n_prod   = w_mul;
                    n_fwd    = 1'b0;
                    if (r_init < w_count) begin
                        w_mem_we = 1'b1;
                        n_init   = r_init + CW'(1);
                        n_fwd    = (r_head == r_init);
                    end
                    n_state = S_ALLOC_END;
                end
            end
            S_ALLOC_END: begin
                if (w_out_free) begin
                    // forward the link written in the read cycle
                    n_head       = r_fwd ? r_init : w_mem_rdata;
                    n_out_valid  = 1'b1;
                    n_out_addr   = (w_base + FIELD_AW'(r_prod)) & AMASK;
                    n_out_status = ST_OK;
                    n_state      = S_IDLE;
                end
            end
            S_FREE_CHK: begin
                n_prod  = w_mul;
                n_off   = (r_addr - w_base) & AMASK;
                n_lt    = (r_addr < w_base);
                n_state = S_FREE_TST;
            end
            S_FREE_TST: begin
                if (r_lt || (r_off >= FIELD_AW'(r_prod))) begin
                    n_status = ST_RANGE;
                    n_state  = S_REPLY;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = S_FREE_DIV;
                end
            end
            S_FREE_DIV: begin
                if (w_div_done && w_out_free) begin
                    // push the freed index onto the head
                    w_mem_we     = 1'b1;
                    w_mem_waddr  = w_div_quo[IW-1:0];
                    w_mem_wdata  = r_head;
                    n_head       = w_div_quo[CW-1:0];
                    n_out_valid  = 1'b1;
                    n_out_addr   = '0;
                    n_out_status = ST_OK;
                    n_state      = S_IDLE;
                end
            end
            S_REPLY: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_addr   = '0;
                    n_out_status = r_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_init      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_init      <= n_init;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_addr       <= n_addr;
        r_prod       <= n_prod;
        r_off        <= n_off;
        r_lt         <= n_lt;
        r_fwd        <= n_fwd;
        r_status     <= n_status;
        r_out_addr   <= n_out_addr;
        r_out_status <= n_out_status;
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_base  <= '0;
            r_cfg_size  <= RST_BLOCK_SIZE;
            r_cfg_count <= RST_BLOCK_COUNT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_POOL_BASE:   r_cfg_base  <= i_cfg_wdata;
                CFG_BLOCK_SIZE:  r_cfg_size  <= i_cfg_wdata[SIZE_W-1:0];
                CFG_BLOCK_COUNT: r_cfg_count <= i_cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_status, r_out_addr};

    // Checks
    `FBPA_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready, r_state != S_IDLE, "request accepted but idle")
    `FBPA_ASSERT_NOW(a_init_monotonic, i_clk, i_rst_n,
        r_init != $past(r_init), r_init == $past(r_init) + CW'(1), "link count jumped")
    `FBPA_ASSERT_NOW(a_freed_index_in_pool, i_clk, i_rst_n,
        r_state == S_FREE_DIV && w_div_done, w_div_quo < PW'(w_count), "freed index past pool")

endmodule

[tb/sv/tb_fixed_block_pool_allocator.sv]
`timescale 1ns / 100ps
// Testbench for fixed_block_pool_allocator: directed and random alloc/free beats checked
// against a scoreboard that keeps its own lazily linked free list. Needs fbpa_pkg and the RTL.
module tb_fixed_block_pool_allocator;
    import fbpa_pkg::*;

    localparam int POOL_DEPTH   = 1024;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 125;
    localparam int SHOW_LIMIT   = 10;

    typedef struct packed {
        logic [FIELD_AW-1:0] addr;
        t_status             status;
    } t_pool_reply;

    // Scoreboard: mirrors the free list and queues the reply each request should produce
    class pool_scoreboard;
        logic [FIELD_AW-1:0] base;
        logic [SIZE_W-1:0]   blk_size;
        logic [COUNT_W-1:0]  blk_count;
        int unsigned         head;
        int unsigned         linked_cnt;
        int unsigned         succ [POOL_DEPTH];
        bit                  succ_valid [POOL_DEPTH];
        t_pool_reply         pending_replies [$];
        int                  mismatches;
        int                  alloc_ok;
        int                  exhausted;
        int                  freed;
        int                  out_of_range;

        function new();
            base      = '0;
            blk_size  = RST_BLOCK_SIZE;
            blk_count = RST_BLOCK_COUNT;
            head      = 0;
            linked_cnt = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [FIELD_AW-1:0] val);
            case (idx)
                CFG_POOL_BASE:   base      = val;
                CFG_BLOCK_SIZE:  blk_size  = val[SIZE_W-1:0];
                CFG_BLOCK_COUNT: blk_count = val[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        // Undersized blocks are widened to the minimum, oversized counts are clipped
        function longint unsigned eff_size();
            return (blk_size < MIN_BLOCK_BYTES) ? longint'(MIN_BLOCK_BYTES) : longint'(blk_size);
        endfunction

        function int unsigned eff_count();
            return (blk_count > POOL_DEPTH) ? POOL_DEPTH : int'(blk_count);
        endfunction

        // True when an allocate now would only follow links that have been written
        function bit alloc_safe();
            if (head >= eff_count())
                return 1'b1;
            return (linked_cnt < eff_count() && head == linked_cnt) || succ_valid[head];
        endfunction

        function t_pool_reply note_request(t_op op, logic [FIELD_AW-1:0] addr);
            longint unsigned size;
            longint unsigned offset;
            logic [63:0]     full;
            int unsigned     cnt;
            int unsigned     idx;
            t_pool_reply     r;
            size     = eff_size();
            cnt      = eff_count();
            r.addr   = '0;
            r.status = ST_OK;
            if (op == OP_ALLOC) begin
                if (head >= cnt) begin
                    r.status = ST_EXHAUSTED;
                    exhausted++;
                end else begin
                    // link the next never-used block before popping the head
                    if (linked_cnt < cnt) begin
                        succ[linked_cnt]       = linked_cnt + 1;
                        succ_valid[linked_cnt] = 1'b1;
                        linked_cnt++;
                    end
                    full   = {16'b0, base} + longint'(head) * size;
                    r.addr = full[FIELD_AW-1:0];
                    head   = succ[head];
                    alloc_ok++;
                end
            end else begin
                offset = longint'(addr) - longint'(base);
                if (addr < base || offset >= longint'(cnt) * size) begin
                    r.status = ST_RANGE;
                    out_of_range++;
                end else begin
                    idx             = int'(offset / size);
                    succ[idx]       = head;
                    succ_valid[idx] = 1'b1;
                    head            = idx;
                    freed++;
                end
            end
            pending_replies.push_back(r);
            return r;
        endfunction

        function void report(string what, logic [63:0] want, logic [63:0] got);
            mismatches++;
            if (mismatches <= SHOW_LIMIT)
                $display("MISMATCH %s: expected %0h, got %0h at %0t", what, want, got, $time);
        endfunction

        function void check_response(logic [55:0] beat);
            t_pool_reply want;
            if (pending_replies.size() == 0) begin
                report("unexpected response beat", '0, beat);
                return;
            end
            want = pending_replies.pop_front();
            if (beat[FIELD_AW-1:0] !== want.addr)
                report("block_addr", want.addr, beat[FIELD_AW-1:0]);
            if (beat[49:48] !== want.status)
                report("status", want.status, beat[49:48]);
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [FIELD_AW-1:0]   s_axis_tdata;    // free_addr[47:0]
    logic                  s_axis_tuser;    // op
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [55:0]           m_axis_tdata;    // block_addr[47:0], status[49:48], zero pad
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [FIELD_AW-1:0]   i_cfg_wdata;

    pool_scoreboard        sb = new();
    logic [FIELD_AW-1:0]   live_blocks [$];
    int                    send_idle_pct;
    int                    recv_stall_pct;
    int                    hold_requests;
    int                    hold_seen;
    int                    hold_left;
    int                    cycle_count;
    int                    req_count;
    int                    cfg_writes;

    fixed_block_pool_allocator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Response side: random stalls, plus a long hold-off when requested
    always @(negedge i_clk) begin
        if (hold_requests != hold_seen) begin
            hold_seen     <= hold_requests;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Check every accepted response beat
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_response(m_axis_tdata);
    end

    // Offer one request beat, with random idle cycles first; returns once accepted
    task automatic send_req(input t_op op, input logic [FIELD_AW-1:0] addr);
        t_pool_reply r;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= addr;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        r = sb.note_request(op, addr);
        req_count++;
        if (op == OP_ALLOC && r.status == ST_OK)
            live_blocks.push_back(r.addr);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FIELD_AW-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Drop valid, wait for every reply, then let the block settle
    task automatic quiesce();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending_replies.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Allocates and frees; frees mostly of live blocks and in-range addresses, some edges and noise
    task automatic run_random_phase(input int items);
        t_op                 op;
        logic [FIELD_AW-1:0] addr;
        longint unsigned     span;
        int                  pick;
        int                  k;
        for (int n = 0; n < items; n++) begin
            span = sb.eff_size() * sb.eff_count();
            op   = ($urandom_range(99) < 55) ? OP_ALLOC : OP_FREE;
            if (op == OP_ALLOC && !sb.alloc_safe())
                op = OP_FREE;
            addr = FIELD_AW'({$urandom, $urandom});
            pick = $urandom_range(99);
            if (op == OP_FREE) begin
                if (pick < 55 && live_blocks.size() != 0) begin
                    k    = $urandom_range(live_blocks.size() - 1);
                    addr = live_blocks[k];
                    live_blocks.delete(k);
                end else if (pick < 75 && span != 0) begin
                    addr = sb.base + FIELD_AW'($urandom_range(32'(span - 1)));
                end else if (pick < 90) begin
                    case ($urandom_range(2))
                        0: addr = sb.base - 1 - FIELD_AW'($urandom_range(3));
                        1: addr = FIELD_AW'(sb.base + span);
                        default: addr = FIELD_AW'(sb.base + span - 1);
                    endcase
                end
            end
            send_req(op, addr);
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = OP_ALLOC;
        m_axis_tready  = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_POOL_BASE;
        i_cfg_wdata    = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests  = 0;
        hold_seen      = 0;
        hold_left      = 0;
        cycle_count    = 0;
        req_count      = 0;
        cfg_writes     = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: reuse, unaligned free, end bound, last byte, all-ones address
        send_req(OP_ALLOC, '0);
        send_req(OP_ALLOC, '1);
        send_req(OP_FREE,  48'd0);
        send_req(OP_ALLOC, '0);
        send_req(OP_FREE,  48'd77);
        send_req(OP_FREE,  48'd65536);
        send_req(OP_FREE,  48'd65535);
        send_req(OP_FREE,  '1);
        send_req(OP_ALLOC, '0);

        // Base at the top of the address space, undersized blocks, clipped count
        quiesce();
        write_reg(CFG_POOL_BASE,   48'hFFFF_FFFF_FFFD);
        write_reg(CFG_BLOCK_SIZE,  48'd3);
        write_reg(CFG_BLOCK_COUNT, 48'd2047);
        send_req(OP_ALLOC, '0);
        send_req(OP_FREE,  48'd2);      // wrapped block address sits below base
        send_req(OP_FREE,  48'hFFFF_FFFF_FFFD);
        send_req(OP_ALLOC, '0);
        send_req(OP_FREE,  48'hFFFF_FFFF_FFFC);

        // Single largest block: exhaustion and exclusive end
        quiesce();
        write_reg(CFG_POOL_BASE,   48'h1000);
        write_reg(CFG_BLOCK_SIZE,  48'd8191);
        write_reg(CFG_BLOCK_COUNT, 48'd1);
        send_req(OP_ALLOC, '0);
        send_req(OP_FREE,  48'h1000);
        send_req(OP_ALLOC, '0);
        send_req(OP_ALLOC, '0);
        send_req(OP_FREE,  48'h1000 + 48'd8191);

        // Empty pool, zero block size
        quiesce();
        write_reg(CFG_BLOCK_COUNT, 48'd0);
        write_reg(CFG_BLOCK_SIZE,  48'd0);
        send_req(OP_ALLOC, '0);
        send_req(OP_FREE,  48'h1000);

        // Random phases, two per idling mode
        for (int p = 0; p < RAND_PHASES; p++) begin
            quiesce();
            case (p / 2)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            case (p % 3)
                0: write_reg(CFG_POOL_BASE, FIELD_AW'({$urandom, $urandom}));
                1: write_reg(CFG_POOL_BASE,
                             48'hFFFF_FFFF_FFFF - FIELD_AW'($urandom_range(4000)));
                default: write_reg(CFG_POOL_BASE, FIELD_AW'($urandom_range(65535)));
            endcase
            case (p)
                0: write_reg(CFG_BLOCK_SIZE, FIELD_AW'($urandom_range(24, 5)));
                1: write_reg(CFG_BLOCK_SIZE, 48'd8191);
                2: write_reg(CFG_BLOCK_SIZE, FIELD_AW'($urandom_range(4, 0)));
                3: write_reg(CFG_BLOCK_SIZE, 48'd4096);
                4: write_reg(CFG_BLOCK_SIZE, 48'd64);
                5: write_reg(CFG_BLOCK_SIZE, FIELD_AW'($urandom_range(4096, 5)));
                6: write_reg(CFG_BLOCK_SIZE, FIELD_AW'($urandom_range(40, 5)));
                default: write_reg(CFG_BLOCK_SIZE, 48'd5);
            endcase
            case (p)
                0: write_reg(CFG_BLOCK_COUNT, 48'd3);
                1: write_reg(CFG_BLOCK_COUNT, 48'd2047);
                2: write_reg(CFG_BLOCK_COUNT, FIELD_AW'($urandom_range(16, 1)));
                3: write_reg(CFG_BLOCK_COUNT, 48'd1);
                4: write_reg(CFG_BLOCK_COUNT, 48'd1024);
                5: write_reg(CFG_BLOCK_COUNT, 48'd2);
                6: write_reg(CFG_BLOCK_COUNT, FIELD_AW'($urandom_range(200, 17)));
                default: write_reg(CFG_BLOCK_COUNT, 48'd8);
            endcase
            // hold off the response side so the block backs up into the request side
            if (p == 0) begin
                @(posedge i_clk);
                hold_requests++;
            end
            run_random_phase(PHASE_ITEMS);
        end
        quiesce();

        $display("Covered %0d requests, %0d register writes: %0d allocated, %0d freed,",
                 req_count, cfg_writes, sb.alloc_ok, sb.freed);
        $display("%0d exhausted replies, %0d out-of-range frees, %0d mismatches.",
                 sb.exhausted, sb.out_of_range, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_replies.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[fixed_block_pool_allocator.f]
+incdir+hw/rtl
hw/rtl/fbpa_pkg.sv
hw/rtl/fbpa_div.sv
hw/rtl/fbpa_link_mem.sv
hw/rtl/fixed_block_pool_allocator.sv
tb/sv/tb_fixed_block_pool_allocator.sv
